### rtl/core/idl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idl_pkg
// Shared widths, operation and status codes, and controller command type for
// the indexed insert/delete list.
// ----------------------------------------------------------------------------
package idl_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 7;
    localparam int ST_W   = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

### rtl/core/idl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idl_ctrl
// Transaction sequencer: accept, execute, hold result until taken.
// ----------------------------------------------------------------------------
module idl_ctrl
    import idl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = o_in_ready && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output handshakes open at once");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("accepted transaction not executed");

    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_out_valid)
        else $error("executed transaction not presented");

endmodule

### rtl/core/idl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idl_datapath
// Row of entry cells with neighbor shift paths, length counter and result
// registers.
// ----------------------------------------------------------------------------
module idl_datapath
    import idl_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [OP_W-1:0]  i_operation,
    input  logic [POS_W-1:0] i_position,
    input  logic [VAL_W-1:0] i_value,
    output logic [VAL_W-1:0] o_read_word,
    output logic [LEN_W-1:0] o_length,
    output logic [ST_W-1:0]  o_status
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [OP_W-1:0]       r_op;
    logic [POS_W-1:0]      r_pos;
    logic [VAL_W-1:0]      r_value;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [WORD_WIDTH-1:0] r_cells [CAPACITY];
    logic [WORD_WIDTH-1:0] n_cells [CAPACITY];
    logic [VAL_W-1:0]      r_read_word;
    logic [ST_W-1:0]       r_status;
    logic [ST_W-1:0]       n_status;

    logic [CMP_W-1:0]      count_x;
    logic [CMP_W-1:0]      pos_x;
    logic                  full;
    logic                  in_range;
    logic                  past_end;
    logic                  do_append;
    logic                  do_insert;
    logic                  do_remove;
    logic                  do_replace;
    logic                  do_read;
    logic [63:0]           val_ext;
    logic [WORD_WIDTH-1:0] val_w;
    logic [WORD_WIDTH-1:0] rd_sel;
    logic [63:0]           rd_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_pos   <= i_position;
            r_value <= i_value;
        end
    end

    assign count_x  = CMP_W'(r_count);
    assign pos_x    = CMP_W'(r_pos);
    assign full     = (count_x >= CMP_W'(CAPACITY));
    assign in_range = (pos_x < count_x);
    assign past_end = (pos_x > count_x);
    assign val_ext  = 64'(r_value);
    assign val_w    = val_ext[WORD_WIDTH-1:0];

    always_comb begin
        n_status   = ST_OK;
        n_count    = r_count;
        do_append  = 1'b0;
        do_insert  = 1'b0;
        do_remove  = 1'b0;
        do_replace = 1'b0;
        do_read    = 1'b0;
        case (r_op)
            OP_APPEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_append = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_INSERT: begin
                if (past_end) begin
                    n_status = ST_BAD_INDEX;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_insert = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (!in_range) begin
                    n_status = ST_BAD_INDEX;
                end else begin
                    do_remove = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            OP_REPLACE: begin
                if (!in_range) begin
                    n_status = ST_BAD_INDEX;
                end else begin
                    do_replace = 1'b1;
                end
            end
            OP_READ: begin
                if (!in_range) begin
                    n_status = ST_BAD_INDEX;
                end else begin
                    do_read = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // per-cell update: load, shift up from below, or shift down from above
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [CMP_W-1:0] IDX  = CMP_W'(gi);
        localparam logic [CMP_W-1:0] IDX1 = CMP_W'(gi + 1);
        logic [WORD_WIDTH-1:0] below;
        logic [WORD_WIDTH-1:0] above;

        if (gi > 0) begin : g_lo
            assign below = r_cells[gi-1];
        end else begin : g_lo0
            assign below = r_cells[gi];
        end
        if (gi < CAPACITY - 1) begin : g_hi
            assign above = r_cells[gi+1];
        end else begin : g_hi0
            assign above = r_cells[gi];
        end

        always_comb begin
            n_cells[gi] = r_cells[gi];
            if (do_append && (count_x == IDX)) begin
                n_cells[gi] = val_w;
            end
            if (do_insert) begin
                if (IDX == pos_x) begin
                    n_cells[gi] = val_w;
                end else if ((IDX > pos_x) && (IDX <= count_x)) begin
                    n_cells[gi] = below;
                end
            end
            if (do_replace && (IDX == pos_x)) begin
                n_cells[gi] = val_w;
            end
            if (do_remove && (IDX >= pos_x) && (IDX1 < count_x)) begin
                n_cells[gi] = above;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) begin
                r_cells[gi] <= n_cells[gi];
            end
        end
    end

    always_comb begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (pos_x == CMP_W'(i)) begin
                rd_sel = rd_sel | r_cells[i];
            end
        end
    end
    assign rd_ext = 64'(rd_sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_read_word <= do_read ? rd_ext[VAL_W-1:0] : '0;
        end
    end

    assign o_read_word = r_read_word;
    assign o_length    = LEN_W'(r_count);
    assign o_status    = r_status;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMP_W'(r_count) <= CMP_W'(CAPACITY)))
        else $error("length above capacity");

    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_status == ST_OK || r_count == $past(r_count)))
        else $error("failed operation changed length");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == OP_CLEAR) |=> (r_count == '0))
        else $error("clear left entries");

endmodule

### rtl/core/indexed_insert_delete_list.sv
`timescale 1ns / 1ps
// An accepted transaction passes through the execute state, then its result
// is presented in the output state. The sequencer holds one transaction at a
// time, and all cells shift in parallel in the execute cycle.
// Reset: synchronous, active low; clears length and sequencer, entries are
// left undefined until written.
// ----------------------------------------------------------------------------
// indexed_insert_delete_list
// Bounded ordered word list with append, insert, remove, replace, read, clear.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list
    import idl_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [2:0] operation, [9:3] position, [41:10] value, [47:42] zero
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [31:0] read_word, [38:32] length, [40:39] status, [47:41] zero
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    t_dp_cmd          cmd;
    logic [VAL_W-1:0] read_word;
    logic [LEN_W-1:0] length;
    logic [ST_W-1:0]  status;

    idl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    idl_datapath #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operation (s_axis_tdata[OP_W-1:0]),
        .i_position  (s_axis_tdata[OP_W+POS_W-1:OP_W]),
        .i_value     (s_axis_tdata[OP_W+POS_W+VAL_W-1:OP_W+POS_W]),
        .o_read_word (read_word),
        .o_length    (length),
        .o_status    (status)
    );

    assign m_axis_tdata = {{(M_DATA_W - VAL_W - LEN_W - ST_W){1'b0}},
                           status, length, read_word};

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for indexed_insert_delete_list. A directed table covers
// empty, full and out-of-range cases, then random bursts of list operations
// run under varying input idling and backpressure. Each result is compared
// against the table's expected value or a behavioral model of the list.
// ----------------------------------------------------------------------------
module testbench;
    import idl_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam int BURST_GROW   = 0;
    localparam int BURST_SHRINK = 1;
    localparam int BURST_MIXED  = 2;

    localparam int PHASE_ITEMS  = 365;
    localparam int RANDOM_ITEMS = 4 * PHASE_ITEMS;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PRINT_LIMIT  = 100;

    typedef struct packed {
        logic [31:0]     word;
        logic [LEN_W-1:0] len;
        logic [ST_W-1:0]  status;
    } t_list_result;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic [7:0]       reps;
        logic             rnd_val;
        logic             typed;
        t_list_result     res;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // op [2:0], position [9:3], value [41:10], zero [47:42]
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // read_word [31:0], length [38:32], status [40:39], zero [47:41]
    logic [M_DATA_W-1:0] m_axis_tdata;

    logic [31:0]  list_words [CAPACITY_DEF];
    int           list_len = 0;
    t_list_result pending_results [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_request = 1'b0;
    bit  hold_served = 1'b0;
    int  hold_left = 0;

    t_stim_row directed_rows [29] = '{
        '{OP_READ,    7'd0,   32'h0,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd0, ST_BAD_INDEX}},
        '{OP_REMOVE,  7'd0,   32'h0,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd0, ST_BAD_INDEX}},
        '{OP_REPLACE, 7'd0,   32'h1234,      8'd1,  1'b0, 1'b1, '{32'h0, 7'd0, ST_BAD_INDEX}},
        '{OP_INSERT,  7'd1,   32'h5,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd0, ST_BAD_INDEX}},
        '{OP_INSERT,  7'd127, 32'h6,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd0, ST_BAD_INDEX}},
        '{OP_INSERT,  7'd0,   32'hFFFF_FFFF, 8'd1,  1'b0, 1'b1, '{32'h0, 7'd1, ST_OK}},
        '{OP_APPEND,  7'd0,   32'h0,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd2, ST_OK}},
        '{OP_READ,    7'd0,   32'h0,         8'd1,  1'b0, 1'b1,
          '{32'hFFFF_FFFF, 7'd2, ST_OK}},
        '{OP_READ,    7'd1,   32'h0,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd2, ST_OK}},
        '{OP_INSERT,  7'd1,   32'hA5A5_5A5A, 8'd1,  1'b0, 1'b0, '0},
        '{OP_READ,    7'd127, 32'h0,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd3, ST_BAD_INDEX}},
        '{OP_RSVD6,   7'd64,  32'hFFFF_FFFF, 8'd1,  1'b0, 1'b1, '{32'h0, 7'd3, ST_OK}},
        '{OP_RSVD7,   7'd127, 32'hFFFF_FFFF, 8'd1,  1'b0, 1'b1, '{32'h0, 7'd3, ST_OK}},
        '{OP_REPLACE, 7'd2,   32'h8000_0001, 8'd1,  1'b0, 1'b0, '0},
        '{OP_REMOVE,  7'd0,   32'h0,         8'd1,  1'b0, 1'b0, '0},
        '{OP_READ,    7'd0,   32'h0,         8'd1,  1'b0, 1'b0, '0},
        '{OP_READ,    7'd2,   32'h0,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd2, ST_BAD_INDEX}},
        '{OP_CLEAR,   7'd0,   32'h0,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd0, ST_OK}},
        '{OP_READ,    7'd0,   32'h0,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd0, ST_BAD_INDEX}},
        '{OP_APPEND,  7'd0,   32'h0,         8'd64, 1'b1, 1'b0, '0},
        '{OP_APPEND,  7'd0,   32'hFFFF_FFFF, 8'd1,  1'b0, 1'b1, '{32'h0, 7'd64, ST_FULL}},
        '{OP_INSERT,  7'd65,  32'h0,         8'd1,  1'b0, 1'b1,
          '{32'h0, 7'd64, ST_BAD_INDEX}},
        '{OP_INSERT,  7'd64,  32'h0,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd64, ST_FULL}},
        '{OP_READ,    7'd63,  32'h0,         8'd1,  1'b0, 1'b0, '0},
        '{OP_READ,    7'd64,  32'h0,         8'd1,  1'b0, 1'b1,
          '{32'h0, 7'd64, ST_BAD_INDEX}},
        '{OP_REMOVE,  7'd63,  32'h0,         8'd1,  1'b0, 1'b0, '0},
        '{OP_INSERT,  7'd63,  32'h0,         8'd1,  1'b1, 1'b0, '0},
        '{OP_REMOVE,  7'd0,   32'h0,         8'd1,  1'b0, 1'b0, '0},
        '{OP_CLEAR,   7'd0,   32'h0,         8'd1,  1'b0, 1'b1, '{32'h0, 7'd0, ST_OK}}
    };

    indexed_insert_delete_list DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // List model: applies one operation and returns the expected result.
    task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                 input logic [VAL_W-1:0] val, output t_list_result res);
        int i;
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_APPEND: begin
                if (list_len >= CAPACITY_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            OP_INSERT: begin
                if (int'(pos) > list_len) begin
                    res.status = ST_BAD_INDEX;
                end else if (list_len >= CAPACITY_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_len; i > int'(pos); i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (int'(pos) >= list_len) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            OP_REPLACE: begin
                if (int'(pos) >= list_len)
                    res.status = ST_BAD_INDEX;
                else
                    list_words[pos] = val;
            end
            OP_READ: begin
                if (int'(pos) >= list_len)
                    res.status = ST_BAD_INDEX;
                else
                    res.word = list_words[pos];
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.len = LEN_W'(list_len);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input bit use_typed,
                           input t_list_result typed_res);
        t_list_result predicted;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, val, pos, op};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_list_op(op, pos, val, predicted);
        pending_results.push_back(use_typed ? typed_res : predicted);
    endtask

    // Result side: backpressure, one long hold-off, and the result check.
    always @(posedge i_clk) begin
        t_list_result want;
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_left     <= HOLD_CYCLES;
            hold_served   <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
        end

        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tdata[31:0], 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.word)
                    report_mismatch("read_word", m_axis_tdata[31:0], want.word);
                if (m_axis_tdata[38:32] !== want.len)
                    report_mismatch("length", 32'(m_axis_tdata[38:32]), 32'(want.len));
                if (m_axis_tdata[40:39] !== want.status)
                    report_mismatch("status", 32'(m_axis_tdata[40:39]), 32'(want.status));
            end
        end
    end

    initial begin : stimulus
        int               r;
        int               k;
        int               n;
        int               pick;
        int               burst_kind;
        int               burst_left;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;

        burst_kind = BURST_GROW;
        burst_left = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < $size(directed_rows); r++) begin
            for (k = 0; k < int'(directed_rows[r].reps); k++) begin
                val = directed_rows[r].rnd_val ? VAL_W'($urandom) : directed_rows[r].val;
                send_op(directed_rows[r].op, directed_rows[r].pos, val,
                        directed_rows[r].typed, directed_rows[r].res);
            end
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                case (n / PHASE_ITEMS)
                    0: begin
                        tx_idle_pct = 0;
                        rx_stall_pct <= 0;
                        hold_request <= 1'b1;
                    end
                    1: begin
                        tx_idle_pct = 81;
                        rx_stall_pct <= 0;
                    end
                    2: begin
                        tx_idle_pct = 0;
                        rx_stall_pct <= 81;
                    end
                    default: begin
                        tx_idle_pct = 31;
                        rx_stall_pct <= 31;
                    end
                endcase
            end

            if (burst_left == 0) begin
                burst_kind = $urandom_range(BURST_GROW, BURST_MIXED);
                burst_left = $urandom_range(20, 120);
            end
            burst_left--;

            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                val = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            else
                val = $urandom;

            if (pick < 6) begin
                // noise: any code, any position
                op  = OP_W'($urandom_range(0, 7));
                pos = POS_W'($urandom_range(0, 127));
            end else begin
                case (burst_kind)
                    BURST_GROW:
                        op = (pick < 50) ? OP_APPEND : (pick < 85) ? OP_INSERT : OP_READ;
                    BURST_SHRINK:
                        op = (pick < 55) ? OP_REMOVE : (pick < 80) ? OP_READ : OP_REPLACE;
                    default:
                        op = (pick < 24) ? OP_APPEND  : (pick < 44) ? OP_INSERT :
                             (pick < 64) ? OP_REMOVE  : (pick < 78) ? OP_REPLACE :
                             (pick < 98) ? OP_READ    : OP_CLEAR;
                endcase
                if ($urandom_range(0, 9) == 0)
                    pos = POS_W'($urandom_range(list_len, 127));
                else if (op == OP_INSERT)
                    pos = POS_W'($urandom_range(0, list_len));
                else
                    pos = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
            end
            send_op(op, pos, val, 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
